### rtl/core/c3f_pkg.sv
// Shared types and constants of the 3x3 convolution filter.
`default_nettype none
package c3f_pkg;
    localparam int unsigned PIX_W = 8;
    localparam int unsigned ROW_W = 16;
    localparam int unsigned COL_W = 10;
    localparam int unsigned SUM_W = 20;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_KTOP   = 3'd2;
    localparam logic [2:0] REG_KMID   = 3'd3;
    localparam logic [2:0] REG_KBOT   = 3'd4;
    localparam logic [2:0] REG_DIV    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_MAC,
        ST_DIV,
        ST_OUT
    } c3f_state_t;

    typedef struct packed {
        logic read;
        logic shift;
        logic mac_start;
        logic mac_step;
        logic div_start;
        logic div_step;
    } c3f_cmd_t;

    typedef struct packed {
        logic interior;
        logic mac_done;
        logic div_done;
    } c3f_status_t;
endpackage
`default_nettype wire

### rtl/core/conv3x3_image_filter_top.sv
// Top level of the 3x3 convolution filter with divisor and clamp.
//   channel   dir  payload
//   s_axis    in   tdata[7:0] = pixel_in
//   m_axis    out  tdata[7:0] pixel_out, [23:8] out_row, [33:24] out_col; tlast = last_of_plane
//   cfg       in   cfg_we, cfg_index[2:0], cfg_data[23:0]
// A border pixel passes through accept, read and shift only; an interior one then
// also runs the multiply-accumulate (nine taps and a done step) and the bit-serial
// divider (twenty quotient bits and a done step) before the output load.
// Reset clears counters, window and the sequencer; line stores are not cleared.
// A finished result waits in the output register; the next pixel is taken while
// it waits, and the sequencer holds only when a new result finds it still full.
`default_nettype none
module conv3x3_image_filter_top #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // pixel_in
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // pixel_out, out_row, out_col, pad
    output logic             m_axis_tlast,   // last_of_plane
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [23:0] ktop_reg, kmid_reg, kbot_reg;
    logic [7:0]  div_reg;

    // Hold configuration; a write takes effect at its clock edge.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1024;
            height_reg <= 16'd1024;
            ktop_reg   <= 24'd0;
            kmid_reg   <= 24'd256;
            kbot_reg   <= 24'd0;
            div_reg    <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                c3f_pkg::REG_WIDTH:  width_reg  <= cfg_data[10:0];
                c3f_pkg::REG_HEIGHT: height_reg <= cfg_data[15:0];
                c3f_pkg::REG_KTOP:   ktop_reg   <= cfg_data;
                c3f_pkg::REG_KMID:   kmid_reg   <= cfg_data;
                c3f_pkg::REG_KBOT:   kbot_reg   <= cfg_data;
                c3f_pkg::REG_DIV:    div_reg    <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    c3f_pkg::c3f_cmd_t    cmd;
    c3f_pkg::c3f_status_t status;
    logic                 out_load, out_free;
    logic [7:0]           res_pixel;
    logic [15:0]          res_row;
    logic [9:0]           res_col;
    logic                 res_last;

    // Output register: free when empty or drained this cycle.
    assign out_free = !m_axis_tvalid || m_axis_tready;

    c3f_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_load(out_load), .out_free(out_free),
        .status(status), .cmd(cmd)
    );

    c3f_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .pixel_in(s_axis_tdata),
        .image_width(width_reg), .image_height(height_reg),
        .kernel_row_top(ktop_reg), .kernel_row_mid(kmid_reg),
        .kernel_row_bottom(kbot_reg), .divisor(div_reg),
        .res_pixel(res_pixel), .res_row(res_row), .res_col(res_col),
        .res_last(res_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tvalid <= 1'b0;
        end
        else if (out_load)
        begin
            m_axis_tvalid <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_axis_tdata <= {6'd0, res_col, res_row, res_pixel};
            m_axis_tlast <= res_last;
        end
    end

    // A new result never lands on an undrained beat.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !out_load)
        else $error("result overwrote pending beat");

    // Input is never taken during a MAC or divide step.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac_step || cmd.div_step |-> !s_axis_tready)
        else $error("input accepted mid-computation");

    // A divide only follows a finished accumulate.
    a_div_after_mac: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> status.mac_done)
        else $error("divide started early");
endmodule
`default_nettype wire

### rtl/core/c3f_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module c3f_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### rtl/core/c3f_ctrl.sv
// Sequencer of the convolution filter: one pixel at a time.
`default_nettype none
module c3f_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_load,
    input  wire logic                 out_free,
    input  wire c3f_pkg::c3f_status_t status,
    output c3f_pkg::c3f_cmd_t         cmd
);
    c3f_pkg::c3f_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= c3f_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            c3f_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.read   = 1'b1;
                    state_next = c3f_pkg::ST_READ;
                end
            end
            c3f_pkg::ST_READ:
            begin
                cmd.shift  = 1'b1;
                state_next = c3f_pkg::ST_SHIFT;
            end
            c3f_pkg::ST_SHIFT:
            begin
                if (status.interior)
                begin
                    cmd.mac_start = 1'b1;
                    state_next    = c3f_pkg::ST_MAC;
                end
                else
                begin
                    state_next = c3f_pkg::ST_IDLE;
                end
            end
            c3f_pkg::ST_MAC:
            begin
                if (status.mac_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = c3f_pkg::ST_DIV;
                end
                else
                begin
                    cmd.mac_step = 1'b1;
                end
            end
            c3f_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = c3f_pkg::ST_OUT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            c3f_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = c3f_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = c3f_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### rtl/core/c3f_datapath.sv
// Line stores, window, counters, serial MAC and restoring divider.
`default_nettype none
module c3f_datapath #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire c3f_pkg::c3f_cmd_t    cmd,
    output c3f_pkg::c3f_status_t      status,
    input  wire logic [7:0]           pixel_in,
    input  wire logic [10:0]          image_width,
    input  wire logic [15:0]          image_height,
    input  wire logic [23:0]          kernel_row_top,
    input  wire logic [23:0]          kernel_row_mid,
    input  wire logic [23:0]          kernel_row_bottom,
    input  wire logic [7:0]           divisor,
    output logic [7:0]                res_pixel,
    output logic [15:0]               res_row,
    output logic [9:0]                res_col,
    output logic                      res_last
);
    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

    logic [CW-1:0] col_reg;
    logic [15:0]   row_reg;
    logic [7:0]    px_reg;
    logic [7:0]    win_reg [3][3];
    logic [7:0]    top_rd, mid_rd;
    logic [AW-1:0] addr;
    logic [CW-1:0] w_last;
    logic [15:0]   h_last;
    logic          col_end, row_end;

    always_comb
    begin
        if (image_width < 11'd3)
        begin
            w_last = CW'(2);
        end
        else if (32'(image_width) > MAX_WIDTH)
        begin
            w_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = CW'(image_width - 11'd1);
        end
        h_last = (image_height < 16'd3) ? 16'd2 : image_height - 16'd1;
    end

    assign addr    = (32'(col_reg) < MAX_WIDTH) ? col_reg[AW-1:0] : AW'(MAX_WIDTH - 1);
    assign col_end = col_reg >= w_last;
    assign row_end = row_reg >= h_last;

    c3f_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_a (
        .clk(clk), .we(cmd.shift), .addr(addr), .wdata(px_reg), .rdata(mid_rd)
    );
    c3f_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_b (
        .clk(clk), .we(cmd.shift), .addr(addr), .wdata(mid_rd), .rdata(top_rd)
    );

    logic interior_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            interior_reg <= 1'b0;
            res_row      <= '0;
            res_col      <= '0;
            res_last     <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[i][k] <= '0;
                end
            end
        end
        else if (cmd.shift)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= top_rd;
            win_reg[1][2] <= mid_rd;
            win_reg[2][2] <= px_reg;
            interior_reg  <= (row_reg >= 16'd2) && (col_reg >= CW'(2));
            res_row       <= row_reg - 16'd1;
            res_col       <= 10'(col_reg - CW'(1));
            res_last      <= row_end && col_end;
            if (col_end)
            begin
                col_reg <= '0;
                row_reg <= row_end ? 16'd0 : row_reg + 16'd1;
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            px_reg <= pixel_in;
        end
    end

    // Serial MAC: one tap per cycle.
    logic [3:0]                 tap_reg;
    logic signed [c3f_pkg::SUM_W-1:0] sum_reg;
    logic [23:0]                krow;
    logic [7:0]                 kbyte, wpix;
    logic [1:0]                 ti, tk;

    assign ti = (tap_reg < 4'd3) ? 2'd0 : (tap_reg < 4'd6) ? 2'd1 : 2'd2;
    assign tk = 2'(tap_reg - 4'(ti) * 4'd3);

    always_comb
    begin
        unique case (ti)
            2'd0:    krow = kernel_row_top;
            2'd1:    krow = kernel_row_mid;
            default: krow = kernel_row_bottom;
        endcase
        kbyte = krow[8*tk +: 8];
        wpix  = win_reg[ti][tk];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_start)
        begin
            tap_reg <= '0;
            sum_reg <= '0;
        end
        else if (cmd.mac_step)
        begin
            tap_reg <= tap_reg + 4'd1;
            sum_reg <= sum_reg + c3f_pkg::SUM_W'($signed({1'b0, wpix}) * $signed(kbyte));
        end
    end

    // Restoring divide of |sum| by divisor, one quotient bit per cycle.
    logic [7:0]               dv;
    logic [c3f_pkg::SUM_W-1:0] mag_reg;
    logic [8:0]               rem_reg;
    logic [4:0]               dcnt_reg;
    logic                     neg_reg;
    logic [8:0]               trial;
    logic [8:0]               rem_sh;

    assign dv     = (divisor == 8'd0) ? 8'd1 : divisor;
    assign rem_sh = {rem_reg[7:0], mag_reg[c3f_pkg::SUM_W-1]};
    assign trial  = rem_sh - {1'b0, dv};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            neg_reg  <= sum_reg[c3f_pkg::SUM_W-1];
            mag_reg  <= sum_reg[c3f_pkg::SUM_W-1] ? c3f_pkg::SUM_W'(-sum_reg)
                                                  : c3f_pkg::SUM_W'(sum_reg);
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + 5'd1;
            if (!trial[8])
            begin
                rem_reg <= trial;
                mag_reg <= {mag_reg[c3f_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                mag_reg <= {mag_reg[c3f_pkg::SUM_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (neg_reg || mag_reg == '0)
        begin
            res_pixel = 8'd0;
        end
        else if (mag_reg > c3f_pkg::SUM_W'(255))
        begin
            res_pixel = 8'd255;
        end
        else
        begin
            res_pixel = mag_reg[7:0];
        end
    end

    assign status.interior = interior_reg;
    assign status.mac_done = tap_reg == 4'd9;
    assign status.div_done = dcnt_reg == 5'(c3f_pkg::SUM_W);
endmodule
`default_nettype wire
